@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ sv/prf_pkg.sv @@
// ----------------------------------------------------------------------------
// prf_pkg
// Shared constants, types and command codes of the primitive root finder.
// ----------------------------------------------------------------------------
package prf_pkg;
  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int VALUE_BITS  = 16;
  localparam int MAX_FACTORS = 8;
  localparam int CNT_BITS    = $clog2(MAX_FACTORS + 1);
  localparam int FIDX_BITS   = $clog2(MAX_FACTORS);
  localparam int EBITS       = $clog2(VALUE_BITS + 1);

  typedef logic [VALUE_BITS-1:0] val_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Request and response of the shared modular multiplier / divider unit.
  typedef struct packed {
    logic                  start;
    logic                  is_div;  // 1: quotient a / m, 0: (a*b) mod m
    logic [VALUE_BITS-1:0] a;
    logic [VALUE_BITS-1:0] b;
    logic [VALUE_BITS-1:0] m;
  } ar_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] q;
    logic [VALUE_BITS-1:0] r;
  } ar_rsp_t;
endpackage

@@ sv/primitive_root_finder.sv @@
// ----------------------------------------------------------------------------
// primitive_root_finder
// Loads a smallest-prime-factor table and answers primitive root queries.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                               | tuser
//  in_     | in  | table_index[15:0] table_value[15:0] prime[15:0]   | cmd
//  out_    | out | root[15:0]                                       | -
//
// A table write is done in the idle state. A query walks the table with a
// division for each factor it reads; each candidate and factor then takes an
// exponent division, a reduction of g, and per exponent bit a square plus a
// multiply when the bit is set. Synchronous active-low reset leaves the table
// as it is. A waiting result holds off new words until out_tready takes it.
module primitive_root_finder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // table_index, table_value, prime_value
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // root
);
  localparam int W  = prf_pkg::VALUE_BITS;
  localparam int AB = prf_pkg::ADDR_BITS;
  localparam int CB = prf_pkg::CNT_BITS;
  localparam int FB = prf_pkg::FIDX_BITS;
  localparam int EB = prf_pkg::EBITS;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD    = 11'b00000000010,
    S_RDW   = 11'b00000000100,
    S_DIVW  = 11'b00000001000,
    S_GNEXT = 11'b00000010000,
    S_EXP   = 11'b00000100000,
    S_EXPW  = 11'b00001000000,
    S_BIT   = 11'b00010000000,
    S_MULW  = 11'b00100000000,
    S_SQW   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t         st_r, st_nxt;
  prf_pkg::val_t  p_r, p_nxt, num_r, num_nxt, f_r, f_nxt, g_r, g_nxt;
  prf_pkg::val_t  e_r, e_nxt, acc_r, acc_nxt, base_r, base_nxt, root_r, root_nxt;
  logic           collect_r, collect_nxt; // 1: first read of a factor
  logic [CB-1:0]  cnt_r, cnt_nxt;
  logic [FB-1:0]  fi_r, fi_nxt;
  logic [EB-1:0]  bit_r, bit_nxt;
  prf_pkg::val_t  flist_r [prf_pkg::MAX_FACTORS];
  logic           fl_we;

  logic           ram_we;
  logic [AB-1:0]  ram_addr;
  prf_pkg::val_t  ram_rd;
  prf_pkg::ar_req_t req;
  prf_pkg::ar_rsp_t rsp;

  logic [15:0] d_idx, d_val, d_p;
  assign d_idx = in_tdata[15:0];
  assign d_val = in_tdata[31:16];
  assign d_p   = in_tdata[47:32];

  prf_table_ram u_ram (.clk(clk), .we(ram_we), .addr(ram_addr),
                       .wdata(W'(d_val)), .rdata(ram_rd));
  prf_arith u_ar (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = 16'(root_r);

  // Sequencer: table walk, then candidate / factor / exponent-bit loops.
  always_comb begin
    st_nxt = st_r; p_nxt = p_r; num_nxt = num_r; f_nxt = f_r; g_nxt = g_r;
    e_nxt = e_r; acc_nxt = acc_r; base_nxt = base_r; root_nxt = root_r;
    collect_nxt = collect_r; cnt_nxt = cnt_r; fi_nxt = fi_r; bit_nxt = bit_r;
    fl_we = 1'b0;
    ram_we = 1'b0; ram_addr = AB'(num_r);
    req = '0;
    case (st_r)
      S_IDLE: begin
        ram_addr = AB'(d_idx);
        if (in_tvalid) begin
          if (in_tuser == prf_pkg::CMD_WRITE) begin
            ram_we = 1'b1;
          end else begin
            p_nxt = W'(d_p); num_nxt = W'(d_p) - W'(1);
            cnt_nxt = '0; collect_nxt = 1'b1; g_nxt = W'(2);
            if (W'(d_p) < W'(2)) begin
              root_nxt = '0; st_nxt = S_OUT;
            end else begin
              st_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        if (num_r <= W'(1)) st_nxt = S_GNEXT;
        else st_nxt = S_RDW;
      end
      S_RDW: begin
        if (collect_r) begin
          if (ram_rd < W'(2)) begin
            st_nxt = S_GNEXT;
          end else begin
            f_nxt = ram_rd; collect_nxt = 1'b0;
            if (cnt_r < CB'(prf_pkg::MAX_FACTORS)) begin
              fl_we = 1'b1; cnt_nxt = cnt_r + 1'b1;
            end
            req.start = 1'b1; req.is_div = 1'b1; req.a = num_r; req.m = ram_rd;
            st_nxt = S_DIVW;
          end
        end else if (ram_rd == f_r) begin
          req.start = 1'b1; req.is_div = 1'b1; req.a = num_r; req.m = f_r;
          st_nxt = S_DIVW;
        end else begin
          collect_nxt = 1'b1; st_nxt = S_RDW;
          // Same address still on the port: reuse the data just read.
          if (ram_rd < W'(2)) st_nxt = S_GNEXT;
          else begin
            f_nxt = ram_rd; collect_nxt = 1'b0;
            if (cnt_r < CB'(prf_pkg::MAX_FACTORS)) begin
              fl_we = 1'b1; cnt_nxt = cnt_r + 1'b1;
            end
            req.start = 1'b1; req.is_div = 1'b1; req.a = num_r; req.m = ram_rd;
            st_nxt = S_DIVW;
          end
        end
      end
      S_DIVW: begin
        if (rsp.done) begin
          num_nxt = rsp.q; st_nxt = S_RD;
        end
      end
      S_GNEXT: begin
        // Try candidate g against the factor list.
        if ({1'b0, g_r} > {1'b0, p_r}) begin
          root_nxt = '0; st_nxt = S_OUT;
        end else if (cnt_r == '0) begin
          root_nxt = g_r; st_nxt = S_OUT;
        end else begin
          fi_nxt = '0; st_nxt = S_EXP;
        end
      end
      S_EXP: begin
        req.start = 1'b1; req.is_div = 1'b1; req.a = p_r - W'(1);
        req.m = flist_r[fi_r]; st_nxt = S_EXPW;
      end
      S_EXPW: begin
        if (rsp.done) begin
          e_nxt = rsp.q; acc_nxt = W'(1); bit_nxt = EB'(W);
          req.start = 1'b1; req.a = g_r; req.b = W'(1); req.m = p_r;
          st_nxt = S_SQW; // base = g mod p
        end
      end
      S_BIT: begin
        if (e_r == '0) begin
          if (acc_r == W'(1)) begin
            g_nxt = g_r + W'(1);
            st_nxt = (g_r == {W{1'b1}}) ? S_OUT : S_GNEXT;
            root_nxt = '0;
          end else if ({1'b0, fi_r} + 1'b1 == CB'(cnt_r)) begin
            root_nxt = g_r; st_nxt = S_OUT;
          end else begin
            fi_nxt = fi_r + 1'b1; st_nxt = S_EXP;
          end
        end else if (e_r[0]) begin
          req.start = 1'b1; req.a = acc_r; req.b = base_r; req.m = p_r;
          st_nxt = S_MULW;
        end else begin
          req.start = 1'b1; req.a = base_r; req.b = base_r; req.m = p_r;
          bit_nxt = '0; st_nxt = S_SQW;
        end
      end
      S_MULW: begin
        if (rsp.done) begin
          acc_nxt = rsp.r;
          req.start = 1'b1; req.a = base_r; req.b = base_r; req.m = p_r;
          bit_nxt = '0; st_nxt = S_SQW;
        end
      end
      S_SQW: begin
        if (rsp.done) begin
          base_nxt = rsp.r;
          if (bit_r == '0) e_nxt = e_r >> 1;
          st_nxt = S_BIT;
        end
      end
      S_OUT: begin
        if (out_tready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt;
    end
    p_r <= p_nxt; num_r <= num_nxt; f_r <= f_nxt; g_r <= g_nxt; e_r <= e_nxt;
    acc_r <= acc_nxt; base_r <= base_nxt; root_r <= root_nxt;
    collect_r <= collect_nxt; fi_r <= fi_nxt; bit_r <= bit_nxt;
    if (fl_we) flist_r[cnt_r[FB-1:0]] <= ram_rd;
  end
endmodule

@@ sv/prf_table_ram.sv @@
// ----------------------------------------------------------------------------
// prf_table_ram
// Smallest-prime-factor table: one synchronous port, registered read.
// ----------------------------------------------------------------------------
module prf_table_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [prf_pkg::ADDR_BITS-1:0] addr,
  input  prf_pkg::val_t                 wdata,
  output prf_pkg::val_t                 rdata
);
  prf_pkg::val_t mem [prf_pkg::TABLE_DEPTH];

  // Write and registered read at one address per cycle; a read during a write returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ sv/prf_arith.sv @@
// ----------------------------------------------------------------------------
// prf_arith
// Bit-serial unit: (a*b) mod m by shift-add-reduce, or a / m by restoring
// division; one bit per cycle.
// ----------------------------------------------------------------------------
module prf_arith (
  input  logic             clk,
  input  logic             rst_n,
  input  prf_pkg::ar_req_t req,
  output prf_pkg::ar_rsp_t rsp
);
  localparam int W  = prf_pkg::VALUE_BITS;
  localparam int EB = prf_pkg::EBITS;

  logic            busy_r, busy_nxt;
  logic            div_r, div_nxt;
  logic [EB-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]    a_r, a_nxt, b_r, b_nxt, m_r, m_nxt, q_r, q_nxt;
  logic [W:0]      acc_r, acc_nxt;
  logic            done_r, done_nxt;

  logic [W+1:0] dbl, add;
  logic [W:0]   red1;

  always_comb begin
    busy_nxt = busy_r; div_nxt = div_r; cnt_nxt = cnt_r;
    a_nxt = a_r; b_nxt = b_r; m_nxt = m_r; q_nxt = q_r; acc_nxt = acc_r;
    done_nxt = 1'b0;
    dbl = {acc_r, 1'b0};
    add = '0;
    red1 = '0;
    if (req.start) begin
      busy_nxt = 1'b1; div_nxt = req.is_div; cnt_nxt = EB'(W);
      a_nxt = req.a; b_nxt = req.b; m_nxt = req.m; q_nxt = '0; acc_nxt = '0;
    end else if (busy_r) begin
      if (div_r) begin
        // Restoring division: shift in next dividend bit.
        add = {acc_r, a_r[W-1]};
        if (add >= {2'b00, m_r}) begin
          add = add - {2'b00, m_r};
          q_nxt = {q_r[W-2:0], 1'b1};
        end else begin
          q_nxt = {q_r[W-2:0], 1'b0};
        end
        acc_nxt = add[W:0];
      end else begin
        // Horner step: acc = 2*acc + bit*b, reduced mod m twice at most.
        add = dbl + (a_r[W-1] ? {2'b00, b_r} : '0);
        if (add >= {1'b0, m_r, 1'b0}) add = add - {1'b0, m_r, 1'b0};
        if (add >= {2'b00, m_r}) add = add - {2'b00, m_r};
        red1 = add[W:0];
        acc_nxt = red1;
      end
      a_nxt = {a_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == EB'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    div_r <= div_nxt; cnt_r <= cnt_nxt; a_r <= a_nxt; b_r <= b_nxt;
    m_r <= m_nxt; q_r <= q_nxt; acc_r <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;
  assign rsp.r    = acc_r[W-1:0];
endmodule

@@ sv/prf_checker.sv @@
// ----------------------------------------------------------------------------
// prf_checker
// Port-level checks of the primitive root finder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module prf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  `CHK_IMPLY(a_no_overlap, clk, rst_n, out_tvalid, !in_tready, "input taken during result")
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
  `CHK_NEXT(a_done, clk, rst_n, out_tvalid && out_tready, in_tready, "not idle after result")
endmodule

bind primitive_root_finder prf_checker u_chk (.*);
